// File: design/ssd_pkg.sv
// Shared types, constants and lookup functions for the seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Largest value that still shows as four decimal digits
  localparam logic [15:0] OVF_LIMIT = 16'd9999;

  // Scan places
  localparam logic [1:0] POS_THOUSANDS = 2'd0;
  localparam logic [1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [1:0] POS_TENS      = 2'd2;
  localparam logic [1:0] POS_UNITS     = 2'd3;

  // Active-low digit enable patterns
  localparam logic [3:0] ENABLES_OFF    = 4'hF;
  localparam logic [3:0] ENABLES_ALL_ON = 4'h0;

  // Segment bits per digit and the last bit index of a frame
  localparam int unsigned SEG_BITS = 8;
  localparam logic [2:0]  LAST_BIT = 3'(SEG_BITS - 1);

  // Reciprocals scaled by 2^24, rounded up; exact floor for values below 10000
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [24:0] RECIP_1000  = 25'd16778;
  localparam logic [24:0] RECIP_100   = 25'd167773;
  localparam logic [24:0] RECIP_10    = 25'd1677722;
  localparam logic [24:0] RECIP_1     = 25'd16777216;

  // Divide-by-ten reciprocal scaled by 2^16, exact for values below 10000
  localparam logic [12:0] RECIP_TEN_16 = 13'd6554;

  // Overflow pattern selector
  localparam logic [3:0] ROW_E = 4'd10;

  // Quotient stage to encoder
  typedef struct packed {
    logic        ovf;
    logic [1:0]  pos;
    logic [13:0] quot;
  } ssd_quot_t;

  // One frame for the serialiser: pattern[7] leaves first
  typedef struct packed {
    logic [7:0] pattern;
    logic [3:0] enables_n;
  } ssd_frame_t;

  // Place divisor reciprocal
  function automatic logic [24:0] place_recip(input logic [1:0] pos);
    logic [24:0] r;
    case (pos)
      POS_THOUSANDS: r = RECIP_1000;
      POS_HUNDREDS:  r = RECIP_100;
      POS_TENS:      r = RECIP_10;
      POS_UNITS:     r = RECIP_1;
      default:       r = RECIP_1;
    endcase
    return r;
  endfunction

  // Active-low segment pattern, first shifted bit in the MSB
  function automatic logic [7:0] seg_pattern(input logic [3:0] row);
    logic [7:0] p;
    case (row)
      4'd0:    p = 8'b1100_0000;
      4'd1:    p = 8'b1111_1001;
      4'd2:    p = 8'b1010_0100;
      4'd3:    p = 8'b1011_0000;
      4'd4:    p = 8'b1001_1001;
      4'd5:    p = 8'b1001_0010;
      4'd6:    p = 8'b1000_0010;
      4'd7:    p = 8'b1111_1000;
      4'd8:    p = 8'b1000_0000;
      4'd9:    p = 8'b1001_0000;
      default: p = 8'b1000_0110;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: design/ssd_front.sv
// Input register and place quotient stage of the seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

module ssd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [15:0]      value_i,
  input  wire logic [1:0]       pos_i,
  output logic                  in_stall_o,
  input  wire logic             take_i,
  output logic                  quot_valid_o,
  output ssd_pkg::ssd_quot_t    quot_o
);
  import ssd_pkg::*;

  logic        s1_valid_q;
  logic        s1_ovf_q;
  logic [1:0]  s1_pos_q;
  logic [13:0] s1_val_q;
  logic        s2_valid_q;
  ssd_quot_t   s2_q, s2_d;
  logic        s1_ready, s2_ready, in_acc;
  logic [38:0] prod;

  // Stage handshakes
  assign s2_ready   = !s2_valid_q || take_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // Place quotient by reciprocal multiply
  always_comb begin
    prod       = {25'd0, s1_val_q} * {14'd0, place_recip(s1_pos_q)};
    s2_d.ovf   = s1_ovf_q;
    s2_d.pos   = s1_pos_q;
    s2_d.quot  = prod[37:RECIP_SHIFT];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ovf_q <= (value_i > OVF_LIMIT);
      s1_pos_q <= pos_i;
      s1_val_q <= value_i[13:0];
    end
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
  end

  assign quot_valid_o = s2_valid_q;
  assign quot_o       = s2_q;

endmodule

`default_nettype wire

// File: design/ssd_encode.sv
// Digit extraction, leading-zero blanking and segment lookup.
`timescale 1ns / 1ps
`default_nettype none

module ssd_encode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ssd_pkg::ssd_quot_t  quot_i,
  input  wire logic                take_i,
  output ssd_pkg::ssd_frame_t      frame_o
);
  import ssd_pkg::*;

  logic        lead_blank_q, lead_blank_d;
  logic [26:0] div_prod;
  logic [9:0]  tenth;
  logic [13:0] tens_part;
  logic [13:0] rem;
  logic [3:0]  digit;
  logic        blank;

  // Units digit of the place quotient: q - 10 * floor(q / 10)
  always_comb begin
    div_prod  = {13'd0, quot_i.quot} * {14'd0, RECIP_TEN_16};
    tenth     = div_prod[25:16];
    tens_part = {1'b0, tenth, 3'd0} + {3'd0, tenth, 1'b0};
    rem       = quot_i.quot - tens_part;
    digit     = rem[3:0];
  end

  // Enables, blanking and next blank flag
  always_comb begin
    blank        = (digit == 4'd0) && ((quot_i.pos == POS_THOUSANDS) || lead_blank_q);
    lead_blank_d = lead_blank_q;
    if (quot_i.ovf) begin
      frame_o.pattern   = seg_pattern(ROW_E);
      frame_o.enables_n = ENABLES_ALL_ON;
    end else begin
      frame_o.pattern = seg_pattern(digit);
      if (quot_i.pos == POS_UNITS) begin
        frame_o.enables_n = ENABLES_OFF & ~(4'b0001 << quot_i.pos);
        lead_blank_d      = 1'b0;
      end else if (blank) begin
        frame_o.enables_n = ENABLES_OFF;
        lead_blank_d      = 1'b1;
      end else begin
        frame_o.enables_n = ENABLES_OFF & ~(4'b0001 << quot_i.pos);
        lead_blank_d      = 1'b0;
      end
    end
  end

  // Blank flag moves with each frame handed to the serialiser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_blank_q <= 1'b0;
    end else if (take_i) begin
      lead_blank_q <= lead_blank_d;
    end
  end

endmodule

`default_nettype wire

// File: design/ssd_ser.sv
// Output serialiser: shifts one frame out as eight result transfers.
`timescale 1ns / 1ps
`default_nettype none

module ssd_ser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 frame_valid_i,
  input  wire ssd_pkg::ssd_frame_t  frame_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      serial_bit_o,
  output logic [3:0]                digit_enables_n_o,
  output logic                      latch_after_o
);
  import ssd_pkg::*;

  logic       busy_q;
  logic [2:0] cnt_q;
  logic [7:0] shreg_q;
  logic [3:0] en_q;
  logic       out_acc, last;

  assign out_acc = busy_q && !out_stall_i;
  assign last    = out_acc && (cnt_q == LAST_BIT);
  assign take_o  = frame_valid_i && (!busy_q || last);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (take_o) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (out_acc) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + 3'd1;
    end
  end

  // Shift register and enables
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      shreg_q <= frame_i.pattern;
      en_q    <= frame_i.enables_n;
    end else if (out_acc) begin
      shreg_q <= {shreg_q[6:0], 1'b0};
    end
  end

  assign out_valid_o       = busy_q;
  assign serial_bit_o      = shreg_q[7];
  assign digit_enables_n_o = en_q;
  assign latch_after_o     = (cnt_q == LAST_BIT);

endmodule

`default_nettype wire

// File: design/seven_segment_scan_driver_core.sv
// Top level of the four-digit multiplexed seven-segment scan driver.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | value_i[15:0]
//  out     | output    | out_valid_o / out_stall_i| serial_bit_o, digit_enables_n_o[3:0],
//          |           |                          | latch_after_o
//
// Each input transfer yields eight output transfers, one segment bit per cycle while the output
// is not stalled; the serialiser's single output bit sets the sustained rate, and it takes
// the next frame together with the last bit of the current one. The first bit is registered
// in turn in the input, quotient and serialiser registers before it is presented.
// Two items can wait in the input and quotient registers while a frame shifts out.
// Reset clears the scan place, the blank flag and all valid bits; stalls on the output
// hold the current bit and back up into in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_driver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             serial_bit_o,
  output logic [3:0]       digit_enables_n_o,
  output logic             latch_after_o
);
  import ssd_pkg::*;

  logic       in_ovf;
  logic [1:0] scan_q;
  logic       in_acc;
  logic       take;
  logic       quot_valid;
  ssd_quot_t  quot;
  ssd_frame_t frame;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_ovf = (value_i > OVF_LIMIT);

  // Scan place advances on every non-overflow transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= POS_THOUSANDS;
    end else if (in_acc && !in_ovf) begin
      scan_q <= scan_q + 2'd1;
    end
  end

  ssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .value_i      (value_i),
    .pos_i        (scan_q),
    .in_stall_o   (in_stall_o),
    .take_i       (take),
    .quot_valid_o (quot_valid),
    .quot_o       (quot)
  );

  ssd_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quot_i  (quot),
    .take_i  (take),
    .frame_o (frame)
  );

  ssd_ser u_ser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_valid_i     (quot_valid),
    .frame_i           (frame),
    .take_o            (take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .serial_bit_o      (serial_bit_o),
    .digit_enables_n_o (digit_enables_n_o),
    .latch_after_o     (latch_after_o)
  );

endmodule

`default_nettype wire

// File: design/ssd_checker.sv
// Port-level checker for the seven-segment scan driver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       serial_bit_o,
  input wire logic [3:0] digit_enables_n_o,
  input wire logic       latch_after_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(serial_bit_o)
      && $stable(digit_enables_n_o) && $stable(latch_after_o))
    else $error("stalled result changed");

  // A frame runs without gaps until its latch bit
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !latch_after_o |=> out_valid_o)
    else $error("frame broken before latch bit");

  // Enables stay fixed within a frame
  a_en_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !latch_after_o |=> $stable(digit_enables_n_o))
    else $error("digit enables changed within a frame");

  // At most one digit lit, or all four for overflow
  a_en_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(digit_enables_n_o) >= 3) || (digit_enables_n_o == 4'h0))
    else $error("illegal digit enable pattern");

endmodule

bind seven_segment_scan_driver_core ssd_checker u_ssd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .serial_bit_o      (serial_bit_o),
  .digit_enables_n_o (digit_enables_n_o),
  .latch_after_o     (latch_after_o)
);

`default_nettype wire
